### hw/rtl/bounded_insertable_list_unit_macros.svh
// ----------------------------------------------------------------------------
// bounded_insertable_list_unit_macros.svh
// assertion macros used by the list unit rtl
// ----------------------------------------------------------------------------
`ifndef BOUNDED_INSERTABLE_LIST_UNIT_MACROS_SVH
`define BOUNDED_INSERTABLE_LIST_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define BIL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BIL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/bil_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_pkg
// constants, codes and types of the bounded insertable list unit
// ----------------------------------------------------------------------------
package bil_pkg;

    localparam int CAPACITY = 16;
    localparam int MODE_W   = 3;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;
    localparam int CNT_W    = 5;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    localparam logic [DATA_W-1:0] BAD_READ = 32'h8000_0001;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 3'd0,
        MODE_FRONT  = 3'd1,
        MODE_AT     = 3'd2,
        MODE_SEARCH = 3'd3,
        MODE_READ   = 3'd4
    } t_mode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOPOS = 2'd2
    } t_status;

    typedef struct packed {
        logic ld_new;
        logic ld_left;
        logic live;
        logic rd_sel;
    } t_cell_ctrl;

endpackage

### hw/rtl/bil_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bil_cell
// one list slot: loads a new word or its left neighbor, compares and reads
// ----------------------------------------------------------------------------
module bil_cell (
    input  logic                               i_clk,
    input  bil_pkg::t_cell_ctrl                i_ctrl,
    input  logic signed [bil_pkg::DATA_W-1:0]  i_new,
    input  logic signed [bil_pkg::DATA_W-1:0]  i_left,
    input  logic signed [bil_pkg::DATA_W-1:0]  i_key,
    output logic signed [bil_pkg::DATA_W-1:0]  o_data,
    output logic                               o_hit,
    output logic        [bil_pkg::DATA_W-1:0]  o_rd
);

    logic signed [bil_pkg::DATA_W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.ld_new) begin
            r_data <= i_new;
        end else if (i_ctrl.ld_left) begin
            r_data <= i_left;
        end
    end

    assign o_data = r_data;
    assign o_hit  = i_ctrl.live && (r_data == i_key);
    assign o_rd   = i_ctrl.rd_sel ? r_data : '0;

endmodule

### hw/rtl/bounded_insertable_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_insertable_list_unit
// ordered list of up to 16 signed words with append, insert, search and read
// ----------------------------------------------------------------------------
// Every slot is a cell that, on an insert, loads either the new word or the
// word of its left neighbor, so the whole tail moves up together, and a
// search compares all live cells at once. The result is registered and
// appears the cycle after the input transfer; a new operation is taken in
// every cycle in which the result register is empty or its result is being
// taken. Size and empty state come from the count field of every result.
// ----------------------------------------------------------------------------
`include "bounded_insertable_list_unit_macros.svh"

module bounded_insertable_list_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // position[4:0], value[36:5], zero fill
    input  logic [2:0]  i_s_tuser,   // mode[2:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata    // status[1:0], hit[2], read_value[34:3], count[39:35]
);

    localparam int N = bil_pkg::CAPACITY;
    localparam int W = bil_pkg::DATA_W;

    logic                         s_xfer;
    bil_pkg::t_mode               mode;
    logic [bil_pkg::POS_W-1:0]    position;
    logic signed [W-1:0]          value;

    logic [bil_pkg::CMP_W-1:0]    pos_x;
    logic [bil_pkg::CMP_W-1:0]    cnt_x;
    logic [bil_pkg::CMP_W-1:0]    ins_pos;
    logic                         is_insert;
    logic                         full;
    logic                         bad_pos;
    logic                         ins_ok;

    bil_pkg::t_cell_ctrl          ctrl  [N];
    logic signed [W-1:0]          data  [N];
    logic                         hits  [N];
    logic [W-1:0]                 rds   [N];
    logic                         any_hit;
    logic [W-1:0]                 rd_or;

    logic [bil_pkg::CNT_W-1:0]    r_count, n_count;
    logic                         r_out_valid;
    bil_pkg::t_status             r_status, n_status;
    logic                         r_hit, n_hit;
    logic [W-1:0]                 r_rd, n_rd;

    assign o_s_tready = !r_out_valid || i_m_tready;
    assign s_xfer     = i_s_tvalid && o_s_tready;

    assign mode     = bil_pkg::t_mode'(i_s_tuser);
    assign position = i_s_tdata[bil_pkg::POS_W-1:0];
    assign value    = i_s_tdata[bil_pkg::POS_W +: W];

    assign pos_x = bil_pkg::CMP_W'(position);
    assign cnt_x = bil_pkg::CMP_W'(r_count);
    assign full  = (r_count >= bil_pkg::CNT_W'(N));

    always_comb begin
        is_insert = 1'b0;
        ins_pos   = '0;
        bad_pos   = 1'b0;
        unique case (mode)
            bil_pkg::MODE_APPEND: begin
                is_insert = 1'b1;
                ins_pos   = cnt_x;
            end
            bil_pkg::MODE_FRONT: begin
                is_insert = 1'b1;
            end
            bil_pkg::MODE_AT: begin
                is_insert = 1'b1;
                ins_pos   = pos_x;
                bad_pos   = (pos_x > cnt_x);
            end
            default: begin
                is_insert = 1'b0;
            end
        endcase
    end

    assign ins_ok = s_xfer && is_insert && !bad_pos && !full;

    genvar gi;
    generate
        for (gi = 0; gi < N; gi++) begin : g_cell
            localparam logic [bil_pkg::CMP_W-1:0] IDX = bil_pkg::CMP_W'(gi);

            assign ctrl[gi].ld_new  = ins_ok && (ins_pos == IDX);
            assign ctrl[gi].ld_left = ins_ok && (IDX > ins_pos) && (IDX <= cnt_x);
            assign ctrl[gi].live    = (IDX < cnt_x);
            assign ctrl[gi].rd_sel  = (mode == bil_pkg::MODE_READ) && (pos_x == IDX);

            if (gi == 0) begin : g_head
                bil_cell u_cell (
                    .i_clk  (i_clk),
                    .i_ctrl (ctrl[gi]),
                    .i_new  (value),
                    .i_left (value),
                    .i_key  (value),
                    .o_data (data[gi]),
                    .o_hit  (hits[gi]),
                    .o_rd   (rds[gi])
                );
            end else begin : g_body
                bil_cell u_cell (
                    .i_clk  (i_clk),
                    .i_ctrl (ctrl[gi]),
                    .i_new  (value),
                    .i_left (data[gi-1]),
                    .i_key  (value),
                    .o_data (data[gi]),
                    .o_hit  (hits[gi]),
                    .o_rd   (rds[gi])
                );
            end
        end
    endgenerate

    always_comb begin
        any_hit = 1'b0;
        rd_or   = '0;
        for (int k = 0; k < N; k++) begin
            any_hit = any_hit | hits[k];
            rd_or   = rd_or | rds[k];
        end
    end

    always_comb begin
        n_status = bil_pkg::ST_OK;
        n_hit    = 1'b0;
        n_rd     = '0;
        n_count  = r_count;
        unique case (mode)
            bil_pkg::MODE_APPEND, bil_pkg::MODE_FRONT, bil_pkg::MODE_AT: begin
                if (bad_pos) begin
                    n_status = bil_pkg::ST_NOPOS;
                end else if (full) begin
                    n_status = bil_pkg::ST_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            bil_pkg::MODE_SEARCH: begin
                n_hit = any_hit;
            end
            bil_pkg::MODE_READ: begin
                if (pos_x < cnt_x) begin
                    n_rd = rd_or;
                end else begin
                    n_status = bil_pkg::ST_NOPOS;
                    n_rd     = bil_pkg::BAD_READ;
                end
            end
            default: begin
                n_status = bil_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_xfer) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_status <= n_status;
            r_hit    <= n_hit;
            r_rd     <= n_rd;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_count, r_rd, r_hit, r_status};

    `BIL_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= bil_pkg::CNT_W'(N), "count above capacity")
    `BIL_ASSERT_NEXT(a_insert_grows, i_clk, i_rst_n, ins_ok, r_count == $past(r_count) + 1'b1, "insert did not grow count")
    `BIL_ASSERT_NEXT(a_count_holds, i_clk, i_rst_n, !ins_ok, $stable(r_count), "count changed without insert")
    `BIL_ASSERT_NOW(a_full_status, i_clk, i_rst_n, r_out_valid && (r_status == bil_pkg::ST_FULL), r_count == bil_pkg::CNT_W'(N), "full status below capacity")

endmodule
